// ----- rtl/tswg_pkg.sv -----
// ----------------------------------------------------------------------------
// tswg_pkg
// Shared constants, register codes and the Taylor pipeline bus for the timed
// sine wave generator.
// ----------------------------------------------------------------------------
package tswg_pkg;

    localparam int PHASE_BITS_DEF    = 16;
    localparam int SINE_FRAC_DEF     = 15;
    localparam int TAYLOR_TERMS      = 7;
    localparam int CFG_INDEX_W       = 3;
    localparam int CFG_DATA_W        = 32;
    localparam int TICK_W            = 32;
    localparam int WAVE_W            = 17;
    localparam int M_TDATA_W         = 24;

    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    localparam logic [15:0] AMPLITUDE_RST    = 16'd0;
    localparam logic [31:0] PERIOD_RST       = 32'd1000;
    localparam logic [15:0] PHASE_OFFSET_RST = 16'd0;
    localparam logic [15:0] BIAS_RST         = 16'd0;
    localparam logic [15:0] STEP_TIME_RST    = 16'd1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_AMPLITUDE    = 3'd0,
        REG_PERIOD_MS    = 3'd1,
        REG_PHASE_OFFSET = 3'd2,
        REG_BIAS         = 3'd3,
        REG_STEP_TIME_MS = 3'd4
    } cfg_reg_t;

    // payload handed from one Taylor term cell to the next
    typedef struct packed {
        logic [1:0]         quad;
        logic [31:0]        x2;
        logic [30:0]        term;
        logic signed [32:0] sum;
    } term_bus_t;

endpackage

// ----- rtl/tswg_div_cell.sv -----
// ----------------------------------------------------------------------------
// tswg_div_cell
// One restoring shift-subtract step of the phase divider, registered.
// ----------------------------------------------------------------------------
module tswg_div_cell import tswg_pkg::*; #(
    parameter int PHASE_BITS = PHASE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [31:0]           period,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [31:0]           rem_in,
    input  logic [31:0]           dvd_in,
    input  logic [PHASE_BITS-1:0] quo_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [31:0]           rem_out,
    output logic [31:0]           dvd_out,
    output logic [PHASE_BITS-1:0] quo_out
);

    logic                  valid_reg;
    logic [31:0]           rem_reg, rem_next;
    logic [31:0]           dvd_reg, dvd_next;
    logic [PHASE_BITS-1:0] quo_reg, quo_next;
    logic [32:0]           partial;
    logic [32:0]           diff;
    logic                  ge;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        partial  = {rem_in, dvd_in[31]};
        diff     = partial - {1'b0, period};
        ge       = (partial >= {1'b0, period});
        rem_next = ge ? diff[31:0] : partial[31:0];
        dvd_next = {dvd_in[30:0], 1'b0};
        quo_next = {quo_in[PHASE_BITS-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_next;
            quo_reg <= quo_next;
        end
    end

    assign out_valid = valid_reg;
    assign rem_out   = rem_reg;
    assign dvd_out   = dvd_reg;
    assign quo_out   = quo_reg;

endmodule

// ----- rtl/tswg_term_cell.sv -----
// ----------------------------------------------------------------------------
// tswg_term_cell
// One Taylor term of sin(x): multiply by x^2, divide by (2k)(2k+1) through a
// reciprocal with correction, and fold the term into the running sum.
// ----------------------------------------------------------------------------
module tswg_term_cell import tswg_pkg::*; #(
    parameter int K = 1
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  term_bus_t bus_in,
    output logic      out_valid,
    input  logic      out_ready,
    output term_bus_t bus_out
);

    localparam int          D     = (2 * K) * (2 * K + 1);
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / D);
    localparam logic [31:0] DIV_C = 32'(D);

    // stage a: term * x2
    logic        va_reg;
    logic        ra;
    term_bus_t   ba_reg;
    logic [31:0] pa_reg, pa_next;
    logic [62:0] mul_a;

    // stage b: reciprocal estimate
    logic        vb_reg;
    logic        rb;
    term_bus_t   bb_reg;
    logic [31:0] pb_reg;
    logic [31:0] qb_reg, qb_next;
    logic [63:0] mul_b;

    // stage c: correction and accumulate
    logic        vc_reg;
    logic        rc;
    term_bus_t   bc_reg, bc_next;
    logic [31:0] back;
    logic [31:0] remd;
    logic [31:0] qc;

    assign rc       = !vc_reg || out_ready;
    assign rb       = !vb_reg || rc;
    assign ra       = !va_reg || rb;
    assign in_ready = ra;

    always_comb begin
        mul_a   = bus_in.term * bus_in.x2;
        pa_next = mul_a[61:30];
        mul_b   = pa_reg * RECIP;
        qb_next = mul_b[63:32];
        back    = qb_reg * DIV_C;
        remd    = pb_reg - back;
        qc      = (remd >= DIV_C) ? qb_reg + 32'd1 : qb_reg;
        bc_next      = bb_reg;
        bc_next.term = qc[30:0];
        if ((K % 2) == 1) begin
            bc_next.sum = bb_reg.sum - $signed({2'b00, qc[30:0]});
        end else begin
            bc_next.sum = bb_reg.sum + $signed({2'b00, qc[30:0]});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else begin
            if (ra) begin
                va_reg <= in_valid;
            end
            if (rb) begin
                vb_reg <= va_reg;
            end
            if (rc) begin
                vc_reg <= vb_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ra) begin
            ba_reg <= bus_in;
            pa_reg <= pa_next;
        end
        if (rb) begin
            bb_reg <= ba_reg;
            pb_reg <= pa_reg;
            qb_reg <= qb_next;
        end
        if (rc) begin
            bc_reg <= bc_next;
        end
    end

    assign out_valid = vc_reg;
    assign bus_out   = bc_reg;

endmodule

// ----- rtl/timed_sine_wave_generator.sv -----
// throughput: one transaction per cycle unless m_tready stalls the output stage
// every stage is registered with its own valid
// the divider chain (32 + PHASE_BITS cells) and seven three-stage Taylor cells set the depth
// synchronous active-low reset clears all valid bits and restores register defaults
// ----------------------------------------------------------------------------
// timed_sine_wave_generator
// Turns a tick count into a scaled and biased sine sample, one sample per tick.
// ----------------------------------------------------------------------------
module timed_sine_wave_generator import tswg_pkg::*; #(
    parameter int PHASE_BITS         = PHASE_BITS_DEF,
    parameter int SINE_FRACTION_BITS = SINE_FRAC_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TICK_W-1:0]      s_tdata,   // [31:0] tick_count
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata    // [16:0] wave_value, rest zero
);

    localparam int NDIV  = 32 + PHASE_BITS;
    localparam int QB    = PHASE_BITS - 2;
    localparam int SFB   = SINE_FRACTION_BITS;
    localparam int MW    = 33 + SFB;
    localparam int PW    = 17 + SFB;
    localparam logic [MW-31:0] MAXC = (MW-30)'((1 << SFB) - 1);

    // configuration registers
    logic [15:0] amplitude_reg;
    logic [31:0] period_reg;
    logic [15:0] phase_offset_reg;
    logic [15:0] bias_reg;
    logic [15:0] step_time_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            amplitude_reg    <= AMPLITUDE_RST;
            period_reg       <= PERIOD_RST;
            phase_offset_reg <= PHASE_OFFSET_RST;
            bias_reg         <= BIAS_RST;
            step_time_reg    <= STEP_TIME_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_AMPLITUDE:    amplitude_reg    <= cfg_data[15:0];
                REG_PERIOD_MS:    period_reg       <= cfg_data;
                REG_PHASE_OFFSET: phase_offset_reg <= cfg_data[15:0];
                REG_BIAS:         bias_reg         <= cfg_data[15:0];
                REG_STEP_TIME_MS: step_time_reg    <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // elapsed time stage
    logic        ve_reg;
    logic        re;
    logic [31:0] elapsed_reg, elapsed_next;
    logic [47:0] mul_e;

    // divider chain wiring
    logic                  dv    [0:NDIV];
    logic                  dr    [0:NDIV];
    logic [31:0]           drem  [0:NDIV];
    logic [31:0]           ddvd  [0:NDIV];
    logic [PHASE_BITS-1:0] dquo  [0:NDIV];

    // phase to angle stage
    logic                  vx_reg;
    logic                  rx;
    logic [30:0]           x_reg, x_next;
    logic [1:0]            quad_reg, quad_next;
    logic [PHASE_BITS-1:0] frac;
    logic [PHASE_BITS+15:0] off_wide;
    logic [PHASE_BITS-1:0] phase;
    logic [QB:0]           rq;
    logic [QB+31:0]        mul_x;

    // x squared stage
    logic        vs_reg;
    logic        rs;
    term_bus_t   sq_reg, sq_next;
    logic [61:0] mul_s;

    // Taylor chain wiring
    logic      tv [0:TAYLOR_TERMS];
    logic      tr [0:TAYLOR_TERMS];
    term_bus_t tb [0:TAYLOR_TERMS];

    // sine code stage
    logic                vn_reg;
    logic                rn;
    logic signed [SFB:0] code_reg, code_next;
    logic [31:0]         s_pos;
    logic [MW-1:0]       mag_wide;
    logic [MW-31:0]      mag_full;
    logic [SFB:0]        mag;

    // amplitude product stage
    logic                 vp_reg;
    logic                 rp;
    logic signed [PW-1:0] prod_reg, prod_next;

    // output stage
    logic              vo_reg;
    logic              ro;
    logic [WAVE_W-1:0] wave_reg, wave_next;

    assign ro       = !vo_reg || m_tready;
    assign rp       = !vp_reg || ro;
    assign rn       = !vn_reg || rp;
    assign re       = !ve_reg || dr[0];
    assign s_tready = re;

    always_comb begin
        mul_e        = s_tdata * step_time_reg;
        elapsed_next = mul_e[31:0];
    end

    assign dv[0]   = ve_reg;
    assign drem[0] = 32'd0;
    assign ddvd[0] = elapsed_reg;
    assign dquo[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < NDIV; gi++) begin : g_div
            tswg_div_cell #(
                .PHASE_BITS(PHASE_BITS)
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .period   (period_reg),
                .in_valid (dv[gi]),
                .in_ready (dr[gi]),
                .rem_in   (drem[gi]),
                .dvd_in   (ddvd[gi]),
                .quo_in   (dquo[gi]),
                .out_valid(dv[gi+1]),
                .out_ready(dr[gi+1]),
                .rem_out  (drem[gi+1]),
                .dvd_out  (ddvd[gi+1]),
                .quo_out  (dquo[gi+1])
            );
        end
    endgenerate

    assign dr[NDIV] = rx;
    assign rx       = !vx_reg || rs;

    always_comb begin
        frac      = (period_reg == 32'd0) ? '0 : dquo[NDIV];
        off_wide  = {phase_offset_reg, PHASE_BITS'(0)};
        phase     = frac + off_wide[PHASE_BITS+15:16];
        quad_next = phase[PHASE_BITS-1:PHASE_BITS-2];
        rq        = {1'b0, phase[QB-1:0]};
        if (quad_next[0]) begin
            rq = {1'b1, QB'(0)} - rq;
        end
        mul_x  = rq * HALF_PI_Q30;
        x_next = mul_x[QB+30:QB];
    end

    assign rs = !vs_reg || tr[0];

    always_comb begin
        mul_s        = x_reg * x_reg;
        sq_next.quad = quad_reg;
        sq_next.x2   = mul_s[61:30];
        sq_next.term = x_reg;
        sq_next.sum  = $signed({2'b00, x_reg});
    end

    assign tv[0] = vs_reg;
    assign tb[0] = sq_reg;

    generate
        for (gi = 0; gi < TAYLOR_TERMS; gi++) begin : g_term
            tswg_term_cell #(
                .K(gi + 1)
            ) u_term (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .in_valid (tv[gi]),
                .in_ready (tr[gi]),
                .bus_in   (tb[gi]),
                .out_valid(tv[gi+1]),
                .out_ready(tr[gi+1]),
                .bus_out  (tb[gi+1])
            );
        end
    endgenerate

    assign tr[TAYLOR_TERMS] = rn;

    always_comb begin
        s_pos    = tb[TAYLOR_TERMS].sum[32] ? 32'd0 : tb[TAYLOR_TERMS].sum[31:0];
        mag_wide = {1'b0, s_pos, SFB'(0)} + (MW'(1) << 29);
        mag_full = mag_wide[MW-1:30];
        if (mag_full > MAXC) begin
            mag_full = MAXC;
        end
        mag       = mag_full[SFB:0];
        code_next = tb[TAYLOR_TERMS].quad[1] ? -$signed(mag) : $signed(mag);
    end

    always_comb begin
        prod_next = PW'($signed(amplitude_reg)) * PW'(code_reg);
        wave_next = prod_reg[SFB+16:SFB] + {bias_reg[15], bias_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ve_reg <= 1'b0;
            vx_reg <= 1'b0;
            vs_reg <= 1'b0;
            vn_reg <= 1'b0;
            vp_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (re) begin
                ve_reg <= s_tvalid;
            end
            if (rx) begin
                vx_reg <= dv[NDIV];
            end
            if (rs) begin
                vs_reg <= vx_reg;
            end
            if (rn) begin
                vn_reg <= tv[TAYLOR_TERMS];
            end
            if (rp) begin
                vp_reg <= vn_reg;
            end
            if (ro) begin
                vo_reg <= vp_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            elapsed_reg <= elapsed_next;
        end
        if (rx) begin
            x_reg    <= x_next;
            quad_reg <= quad_next;
        end
        if (rs) begin
            sq_reg <= sq_next;
        end
        if (rn) begin
            code_reg <= code_next;
        end
        if (rp) begin
            prod_reg <= prod_next;
        end
        if (ro) begin
            wave_reg <= wave_next;
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = {(M_TDATA_W-WAVE_W)'(0), wave_reg};

endmodule
